FILE: rtl/swa_pkg.sv
// Shared constants and types for the sliding-window average block.
// No dependencies; compile first.
package swa_pkg;

  localparam int MAX_WINDOW_DEF  = 64;  // default ring depth
  localparam int SAMPLE_BITS_DEF = 16;  // default sample width
  localparam int CFG_W           = 7;   // width of the window_length register
  localparam int RESET_WINDOW    = 16;  // window length after reset

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic busy;  // division in progress
    logic done;  // one-cycle pulse, quotient valid from here on
  } swa_div_stat_t;

endpackage

FILE: rtl/sliding_window_average.sv
// Sliding-window (moving) average over the last window_length signed samples.
// Depends on swa_pkg, swa_ram and swa_div.
//
// Each input word carries one signed sample. The block keeps the last window_length
// samples in a ring RAM (depth MAX_WINDOW), a running sum and a write pointer. For each
// sample it drops the oldest slot from the sum, adds the new sample, overwrites that slot,
// advances the pointer modulo window_length and returns one output word: the sum divided
// by window_length, truncated toward zero. The divider produces one quotient bit per cycle
// over SUM_W = SAMPLE_BITS + log2(MAX_WINDOW) bits (22 at the defaults), and s_axis_tready
// is low while a word is being processed, so a new sample waits for the last one. The
// result sits in an output register, so the next sample is taken while it waits. Writing
// window_length (only while idle) clamps 0 to 1 and values above MAX_WINDOW to MAX_WINDOW,
// and clears the ring, sum and pointer at once: per-slot valid bits make unwritten slots
// read as zero, so there is no clearing pass after reset or after a write.
module sliding_window_average #(
  parameter int MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // slave side: tdata = {pad, sample[SAMPLE_BITS-1:0]}
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [DATA_W-1:0]        s_axis_tdata,
  // master side: tdata = {pad, average[SAMPLE_BITS-1:0]}
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [DATA_W-1:0]        m_axis_tdata,
  // window_length register
  input  logic                     cfg_we_i,
  input  logic [swa_pkg::CFG_W-1:0] cfg_wdata_i
);

  import swa_pkg::*;

  localparam int PTR_W   = $clog2(MAX_WINDOW);
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int RST_LEN = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a sample
  localparam logic [2:0] ST_READ  = 3'd1;  // oldest slot on RAM output; update sum and ring
  localparam logic [2:0] ST_START = 3'd2;  // launch the divider on the new sum
  localparam logic [2:0] ST_WAIT  = 3'd3;  // divider running
  localparam logic [2:0] ST_OUT   = 3'd4;  // move quotient into the output register

  logic [2:0]                     state_q, state_d;
  logic [LEN_W-1:0]               len_q, len_d;
  logic [PTR_W-1:0]               pos_q, pos_d;
  logic signed [SUM_W-1:0]        sum_q, sum_d;
  logic [MAX_WINDOW-1:0]          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0]  sample_q, sample_d;
  logic                           out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]         avg_q, avg_d;

  logic                           accept;
  logic                           ram_we;
  logic [SAMPLE_BITS-1:0]         ram_rdata;
  logic signed [SAMPLE_BITS-1:0]  oldest;
  logic [LEN_W-1:0]               pos_inc;
  logic                           div_start;
  swa_div_stat_t                  div_stat;
  logic [SUM_W-1:0]               div_quo;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  // slots never written since the last clear read as zero
  assign oldest  = valid_q[pos_q] ? signed'(ram_rdata) : '0;
  assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);

  assign ram_we    = (state_q == ST_READ);
  assign div_start = (state_q == ST_START);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    valid_d     = valid_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q;
    avg_d       = avg_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sample_d = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        sum_d          = sum_q - SUM_W'(oldest) + SUM_W'(sample_q);
        valid_d[pos_q] = 1'b1;
        pos_d          = (pos_inc == len_q) ? '0 : pos_inc[PTR_W-1:0];
        state_d        = ST_START;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          avg_d       = div_quo[SAMPLE_BITS-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register write: clamp, then clear the window
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        len_d = LEN_W'(1);
      end else if (int'(cfg_wdata_i) > MAX_WINDOW) begin
        len_d = LEN_W'(MAX_WINDOW);
      end else begin
        len_d = LEN_W'(cfg_wdata_i);
      end
      pos_d   = '0;
      sum_d   = '0;
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(RST_LEN);
      pos_q       <= '0;
      sum_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    avg_q    <= avg_d;
  end

  // ring store: read the oldest slot as the sample is taken, overwrite it next cycle
  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (sample_q),
    .re_i    (accept),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  swa_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (len_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(avg_q);

`ifndef SYNTHESIS
  // new samples only come in while the divider is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy)
    else $error("sample accepted while divider busy");

  // a divide completes only when the sequencer is waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_WAIT))
    else $error("divider done outside wait state");

  // an output word only appears from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output word without a finished divide");

  // the write pointer stays inside the active window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(pos_q) < len_q)
    else $error("write pointer outside window");
`endif

endmodule

FILE: rtl/swa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/swa_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Depends on swa_pkg (status struct).
module swa_div #(
  parameter int SUM_W = 22,
  parameter int LEN_W = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SUM_W-1:0]  dividend_i,
  input  logic [LEN_W-1:0]         divisor_i,
  output swa_pkg::swa_div_stat_t   stat_o,
  output logic [SUM_W-1:0]         quotient_o
);

  import swa_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [LEN_W-1:0] dvs_q, dvs_d;
  logic [LEN_W:0]   rem_q, rem_d;
  logic [SUM_W-1:0] quo_q, quo_d;

  logic [LEN_W:0]   rem_sh;
  logic [LEN_W+1:0] diff;

  assign rem_sh = {rem_q[LEN_W-1:0], quo_q[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          neg_d   = dividend_i[SUM_W-1];
          quo_d   = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
          dvs_d   = divisor_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = D_RUN;
        end
      end
      D_RUN: begin
        // restoring step: keep the trial difference when it stays non-negative
        if (!diff[LEN_W+1]) begin
          rem_d = diff[LEN_W:0];
          quo_d = {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[SUM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          state_d = D_FIX;
        end
      end
      D_FIX: begin
        quo_d   = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = (state_q != D_IDLE);
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

FILE: tb/tb.sv
// Self-checking bench for sliding_window_average: stream in, stream out, window register.
// Depends on swa_pkg and the sliding_window_average RTL; nothing else.
`timescale 1ns / 1ps

module tb;

  import swa_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [SW-1:0]     s_axis_tdata;   // [15:0] sample
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [SW-1:0]     m_axis_tdata;   // [15:0] average
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;

  sliding_window_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 8 ns period
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the averager: ring of samples, running sum, write slot, length.
  // ---------------------------------------------------------------------------
  shortint           ring [MAX_WINDOW_DEF];
  longint            ring_sum    = 0;
  int                wr_slot     = 0;
  int                win_len     = RESET_WINDOW;
  logic [SW-1:0]     expected_avg [$];
  int                fail_count  = 0;
  int                sent_count  = 0;
  bit                idle_on     = 1'b1;   // random gaps / stalls enabled
  int                stall_left  = 0;

  initial foreach (ring[i]) ring[i] = 0;

  // Length register write: 0 reads as 1, anything past the ring depth saturates.
  function automatic void load_window(input logic [CFG_W-1:0] v);
    if (v == 0)
      win_len = 1;
    else if (v > MAX_WINDOW_DEF)
      win_len = MAX_WINDOW_DEF;
    else
      win_len = int'(v);
    foreach (ring[i]) ring[i] = 0;
    ring_sum = 0;
    wr_slot  = 0;
  endfunction

  // Drop the oldest slot, add the new sample, advance, divide (truncates toward zero).
  function automatic logic [SW-1:0] window_mean(input logic signed [SW-1:0] x);
    longint q;
    ring_sum = ring_sum - longint'(ring[wr_slot]) + longint'(x);
    ring[wr_slot] = x;
    wr_slot = (wr_slot + 1 >= win_len) ? 0 : wr_slot + 1;
    q = ring_sum / longint'(win_len);
    return q[SW-1:0];
  endfunction

  // Everything is sampled at the rising edge; inputs only move on the falling one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_avg.size() == 0) begin
          $error("average word 0x%h with nothing expected", m_axis_tdata);
          fail_count++;
        end else begin
          logic [SW-1:0] want;
          want = expected_avg.pop_front();
          if (m_axis_tdata[SW-1:0] !== want) begin
            $error("average: expected %0d, got %0d",
                   $signed(want), $signed(m_axis_tdata[SW-1:0]));
            fail_count++;
          end
        end
      end
      if (cfg_we_i)
        load_window(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready)
        expected_avg.push_back(window_mean(s_axis_tdata[SW-1:0]));
    end
  end

  // Receiver: stall bursts of random length while idling is enabled.
  always @(negedge clk_i) begin
    if (idle_on && stall_left == 0 && $urandom_range(5) == 0)
      stall_left = $urandom_range(1, 19);
    if (!idle_on)
      stall_left = 0;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks; all are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [SW-1:0] x);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Sender holds off until every expected average has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_avg.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return SW'($urandom_range(0, 15) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes with the length left at its reset value.
  task automatic test_reset_length();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd0);
  endtask

  // Zero taken as one, saturation above the ring depth, full windows at the rails.
  task automatic test_length_edges();
    write_window(7'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    write_window(7'd127);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    write_window(7'd2);
    repeat (3) send_sample(16'sh8000);   // window full of the negative rail
    repeat (2) send_sample(16'sh7fff);
    write_window(7'd65);
    send_sample(16'sh5555);
    write_window(7'd64);
    send_sample(16'shaaaa);
    send_sample(16'sh7fff);
    write_window(7'd3);
    repeat (3) send_sample(-16'sd1);     // -1/3 must truncate to 0, -3/3 to -1
    send_sample(16'sd1);
  endtask

  // Sender stops dead until the output side has caught up, then resumes.
  task automatic test_pause();
    write_window(7'd5);
    repeat (8) send_sample(pick_sample());
    drain_results();
    repeat (8) send_sample(pick_sample());
  endtask

  // Phases with random lengths; mostly random samples, some constant runs.
  task automatic test_random_phases(input int n_items);
    int               stop_at;
    int               eff_len;
    int               n_phase;
    logic [CFG_W-1:0] len;
    logic [SW-1:0]    level;
    bit               flat;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      case ($urandom_range(7))
        0:       len = 7'd1;
        1:       len = 7'd64;
        2:       len = 7'd0;
        3:       len = 7'd127;
        4:       len = 7'd2;
        default: len = CFG_W'($urandom_range(0, 127));
      endcase
      write_window(len);
      idle_on = ($urandom_range(4) != 0);
      eff_len = (len == 0) ? 1 : (len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(len);
      n_phase = $urandom_range(10, 2 * eff_len + 10);
      if (n_phase > stop_at - sent_count)
        n_phase = stop_at - sent_count;
      flat    = ($urandom_range(4) == 0);
      level   = pick_sample();
      repeat (n_phase) begin
        if ($urandom_range(40) == 0)
          drain_results();
        if (flat && $urandom_range(7) != 0)
          send_sample(level);
        else
          send_sample(pick_sample());
      end
    end
  endtask

  // Closing stretch with no gaps on either side.
  task automatic test_steady_tail();
    write_window(7'd7);
    idle_on = 1'b0;
    repeat (60) send_sample(pick_sample());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_length();
    test_length_edges();
    test_pause();
    test_random_phases(950);
    test_steady_tail();

    drain_results();
    repeat (40) @(negedge clk_i);
    if (expected_avg.size() != 0) begin
      $error("%0d expected averages never arrived", expected_avg.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("sliding_window_average regression: pass");
    end else begin
      $display("sliding_window_average regression: fail");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #5000000;
    $display("sliding_window_average regression: fail");
    $finish;
  end

endmodule
